### hdl/pbmu_pkg.sv
// Package for the pixel blend mode unit: blend mode codes and arithmetic constants.
package pbmu_pkg;

  localparam int unsigned ModeWidth = 4;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned ProdWidth = 2 * ByteWidth;

  // Reciprocal of 127 as 129 / 2^14; the estimate is low by at most one
  localparam int unsigned RecipMult  = 129;
  localparam int unsigned RecipShift = 14;
  localparam int unsigned EstWidth   = 9;
  localparam int unsigned HalfDiv    = 127;

  typedef enum logic [ModeWidth-1:0] {
    MODE_AVERAGE    = 4'd0,
    MODE_MULTIPLY   = 4'd1,
    MODE_SCREEN     = 4'd2,
    MODE_DARKEN     = 4'd3,
    MODE_LIGHTEN    = 4'd4,
    MODE_DIFFERENCE = 4'd5,
    MODE_NEGATION   = 4'd6,
    MODE_EXCLUSION  = 4'd7,
    MODE_OVERLAY    = 4'd8
  } mode_t;

endpackage

### hdl/pixel_blend_mode_unit.sv
// Pixel blend mode unit: four-stage pipelined 8-bit channel blender.
//
// Blends two channel bytes into one under the mode held in the configuration
// register (0 average, 1 multiply, 2 screen, 3 darken, 4 lighten, 5 difference,
// 6 negation, 7 exclusion, 8 overlay; other codes pass second_byte through).
// One item is accepted per clock while in_stall is low; each goes through operand
// select, an 8x8 multiply, the exact quotient by 255 and a reciprocal estimate
// for the divide by 127, then a correction step and the final mode select into the
// output register. Every stage holds only while the stage after it is full and
// blocked, so bubbles close up and a stalled output still lets earlier stages
// fill. The mode is sampled per item at the input; write it only while idle.
module pixel_blend_mode_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbmu_pkg::ModeWidth-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbmu_pkg::ByteWidth-1:0]   first_byte,
  input  logic [pbmu_pkg::ByteWidth-1:0]   second_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pbmu_pkg::ByteWidth-1:0]   blended_byte
);
  import pbmu_pkg::*;

  // configuration register
  mode_t blend_mode;

  // stage enables
  logic en1, en2, en3, en_out;

  // stage 1: operands
  logic                 s1_valid;
  mode_t                s1_mode;
  logic [ByteWidth-1:0] s1_a, s1_b, s1_x, s1_y;
  logic                 inv_ops;

  // stage 2: product
  logic                 s2_valid;
  mode_t                s2_mode;
  logic [ByteWidth-1:0] s2_a, s2_b;
  logic [ProdWidth-1:0] s2_prod;

  // stage 3: quotient estimates
  logic                 s3_valid;
  mode_t                s3_mode;
  logic [ByteWidth-1:0] s3_a, s3_b;
  logic [ProdWidth-1:0] s3_prod;
  logic [ByteWidth-1:0] s3_q255;
  logic [EstWidth-1:0]  s3_est;
  logic [ProdWidth:0]   q255_sum;
  logic [ProdWidth+7:0] recip_prod;

  // stage 4: correction and select
  logic [ProdWidth:0]   rem127;
  logic [EstWidth-1:0]  q127;
  logic [ByteWidth:0]   sum_ab;
  logic [ByteWidth-1:0] diff_ab;
  logic [ByteWidth-1:0] result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_AVERAGE;
    end else if (cfg_valid && cfg_ready) begin
      blend_mode <= mode_t'(cfg_data);
    end
  end

  // a stage advances when the one after it is empty or advancing
  assign en_out   = !out_valid || !out_stall;
  assign en3      = !s3_valid || en_out;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_stall = !en1;

  // screen and the upper half of overlay work on inverted operands
  assign inv_ops = (blend_mode == MODE_SCREEN) ||
                   ((blend_mode == MODE_OVERLAY) && first_byte[ByteWidth-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode <= blend_mode;
      s1_a    <= first_byte;
      s1_b    <= second_byte;
      s1_x    <= inv_ops ? ~first_byte  : first_byte;
      s1_y    <= inv_ops ? ~second_byte : second_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mode <= s1_mode;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_prod <= ProdWidth'(s1_x) * ProdWidth'(s1_y);
    end
  end

  // p / 255 = (p + (p >> 8) + 1) >> 8, exact for any product of two bytes
  assign q255_sum   = {1'b0, s2_prod} + (ProdWidth+1)'(s2_prod >> ByteWidth) +
                      (ProdWidth+1)'(1);
  assign recip_prod = (ProdWidth+8)'(s2_prod) * (ProdWidth+8)'(RecipMult);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_mode <= s2_mode;
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_prod <= s2_prod;
      s3_q255 <= q255_sum[ByteWidth +: ByteWidth];
      s3_est  <= recip_prod[RecipShift +: EstWidth];
    end
  end

  // bump the estimate once when the remainder reaches the divisor
  assign rem127 = {1'b0, s3_prod} - ((ProdWidth+1)'(s3_est) * (ProdWidth+1)'(HalfDiv));
  assign q127   = s3_est + EstWidth'(rem127 >= (ProdWidth+1)'(HalfDiv));
  assign sum_ab = {1'b0, s3_a} + {1'b0, s3_b};
  assign diff_ab = (s3_a > s3_b) ? (s3_a - s3_b) : (s3_b - s3_a);

  always_comb begin
    result = s3_b;
    unique case (s3_mode)
      MODE_AVERAGE:    result = sum_ab[ByteWidth:1];
      MODE_MULTIPLY:   result = s3_q255;
      MODE_SCREEN:     result = ~s3_q255;
      MODE_DARKEN:     result = (s3_a < s3_b) ? s3_a : s3_b;
      MODE_LIGHTEN:    result = (s3_a > s3_b) ? s3_a : s3_b;
      MODE_DIFFERENCE: result = diff_ab;
      MODE_NEGATION:   result = sum_ab[ByteWidth] ? ~sum_ab[ByteWidth-1:0] - ByteWidth'(1)
                                                   : sum_ab[ByteWidth-1:0];
      MODE_EXCLUSION:  result = sum_ab[ByteWidth-1:0] - q127[ByteWidth-1:0];
      MODE_OVERLAY:    result = s3_a[ByteWidth-1] ? ~q127[ByteWidth-1:0]
                                                  : q127[ByteWidth-1:0];
      default:         result = s3_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      blended_byte <= result;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && s3_valid && out_valid))
    else $error("input stalled while the pipeline has a free stage");

  a_stage3_delivers: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && en_out) |=> out_valid)
    else $error("item lost between stage 3 and the output register");

  a_div127_corrected: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (rem127 < (ProdWidth+1)'(2 * HalfDiv)))
    else $error("reciprocal estimate for the divide by 127 is off by more than one");
`endif

endmodule

### verif/tb_pixel_blend_mode_unit.sv
// Self-checking testbench for the pixel blend mode unit across all blend modes.
module tb_pixel_blend_mode_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pbmu_pkg::*;

  typedef struct packed {
    logic [ByteWidth-1:0] a;
    logic [ByteWidth-1:0] b;
  } byte_pair_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ModeWidth-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ByteWidth-1:0] first_byte = '0;
  logic [ByteWidth-1:0] second_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ByteWidth-1:0] blended_byte;

  byte_pair_t           pair_queue[$];
  logic [ByteWidth-1:0] blend_expect[$];
  logic [ModeWidth-1:0] model_mode = MODE_AVERAGE;
  int unsigned          pairs_offered = 0;
  int unsigned          pairs_taken = 0;
  int unsigned          errors = 0;
  logic                 calm = 1'b0;
  logic                 squeeze = 1'b0;
  logic                 squeeze_done = 1'b0;
  int                   hold_left = 0;

  pixel_blend_mode_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .blended_byte (blended_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ByteWidth-1:0] blend_byte_of(logic [ModeWidth-1:0] mode,
                                                         logic [ByteWidth-1:0] a_in,
                                                         logic [ByteWidth-1:0] b_in);
    int a;
    int b;
    int r;
    a = a_in;
    b = b_in;
    case (mode)
      MODE_AVERAGE:    r = (a + b) / 2;
      MODE_MULTIPLY:   r = (a * b) / 255;
      MODE_SCREEN:     r = 255 - ((255 - a) * (255 - b)) / 255;
      MODE_DARKEN:     r = (a < b) ? a : b;
      MODE_LIGHTEN:    r = (a > b) ? a : b;
      MODE_DIFFERENCE: r = (a > b) ? a - b : b - a;
      MODE_NEGATION:   r = 255 - (((a + b) > 255) ? (a + b) - 255 : 255 - (a + b));
      MODE_EXCLUSION:  r = (a + b) - (a * b) / 127;
      MODE_OVERLAY: begin
        if (a < 128) r = (a * b) / 127;
        else r = 255 - ((255 - a) * (255 - b)) / 127;
      end
      default:         r = b;
    endcase
    return r[ByteWidth-1:0];
  endfunction

  // Lean toward the edges and the midpoint of the byte range now and then
  function automatic logic [ByteWidth-1:0] pick_byte();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return ByteWidth'($urandom_range(0, 255));
    endcase
  endfunction

  // Track register writes and accepted items, check results in order
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (blend_expect.size() == 0) begin
          $error("blended_byte: no item expected, actual %0d", blended_byte);
          errors <= errors + 1;
        end else begin
          if (blended_byte !== blend_expect[0]) begin
            $error("blended_byte: expected %0d, actual %0d", blend_expect[0], blended_byte);
            errors <= errors + 1;
          end
          void'(blend_expect.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        blend_expect.push_back(blend_byte_of(model_mode, first_byte, second_byte));
        pairs_taken <= pairs_taken + 1;
      end
      if (cfg_valid && cfg_ready) model_mode <= cfg_data;
    end
  end

  // Sender: advance once the held item is taken, idle at random
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pairs_taken == pairs_offered) begin
      if (pair_queue.size() == 0 || (!calm && $urandom_range(0, 99) < 26)) begin
        in_valid <= 1'b0;
      end else begin
        first_byte    <= pair_queue[0].a;
        second_byte   <= pair_queue[0].b;
        void'(pair_queue.pop_front());
        in_valid      <= 1'b1;
        pairs_offered <= pairs_offered + 1;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze && !squeeze_done) begin
      out_stall    <= 1'b1;
      hold_left    <= 80;
      squeeze_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  task automatic wait_idle();
    while (pair_queue.size() != 0 || pairs_taken != pairs_offered || blend_expect.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(logic [ModeWidth-1:0] mode);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pair(logic [ByteWidth-1:0] a, logic [ByteWidth-1:0] b);
    byte_pair_t p;
    p.a = a;
    p.b = b;
    pair_queue.push_back(p);
  endtask

  initial begin
    logic [ModeWidth-1:0] mode;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset mode is average
    push_pair(8'd0, 8'd0);
    push_pair(8'd255, 8'd255);
    push_pair(8'd0, 8'd255);
    set_mode(MODE_EXCLUSION);
    push_pair(8'd255, 8'd255); // wraps below zero
    push_pair(8'd0, 8'd0);
    push_pair(8'd127, 8'd127);
    set_mode(MODE_OVERLAY);
    push_pair(8'd127, 8'd255);
    push_pair(8'd128, 8'd0);
    push_pair(8'd128, 8'd255);
    set_mode(MODE_MULTIPLY);
    push_pair(8'd255, 8'd255);
    push_pair(8'd254, 8'd255);
    set_mode(MODE_SCREEN);
    push_pair(8'd0, 8'd0);
    push_pair(8'd255, 8'd1);
    set_mode(MODE_NEGATION);
    push_pair(8'd255, 8'd255);
    push_pair(8'd0, 8'd255);
    set_mode(MODE_DIFFERENCE);
    push_pair(8'd0, 8'd255);
    push_pair(8'd255, 8'd0);
    // Unused codes pass second_byte through
    set_mode(4'd9);
    push_pair(8'd12, 8'd200);
    set_mode(4'd15);
    push_pair(8'd255, 8'd0);
    push_pair(8'd0, 8'd255);

    for (int phase = 0; phase < 18; phase++) begin
      mode = (phase < 16) ? phase[ModeWidth-1:0] : ModeWidth'($urandom_range(0, 15));
      set_mode(mode);
      calm    <= (phase == 6);
      squeeze <= (phase == 3);
      for (int i = 0; i < 25; i++) push_pair(pick_byte(), pick_byte());
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_pixel_blend_mode_unit passed");
    end else begin
      $display("tb_pixel_blend_mode_unit failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_pixel_blend_mode_unit failed");
    $finish;
  end

endmodule

### filelist.f
hdl/pbmu_pkg.sv
hdl/pixel_blend_mode_unit.sv
verif/tb_pixel_blend_mode_unit.sv
